@@ rtl/catb_pkg.sv @@
package catb_pkg;

    localparam int COORD_BITS_DEFAULT = 12;
    localparam int ORIGIN_BITS = 12;
    localparam int DIM_BITS = 13;
    localparam int CHAN_BITS = 8;
    localparam int WORD_BITS = 32;
    localparam int ADDR_BITS = 24;
    localparam int PADDR_BITS = 5;

    localparam logic [CHAN_BITS-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [CHAN_BITS-1:0] ALPHA_CLEAR = 8'h00;
    localparam logic [CHAN_BITS:0] BLEND_ONE = 9'd256;

    localparam logic [DIM_BITS-1:0] SCREEN_WIDTH_RESET = 13'd640;
    localparam logic [DIM_BITS-1:0] SCREEN_HEIGHT_RESET = 13'd480;
    localparam logic [DIM_BITS-1:0] TEXTURE_DIM_RESET = 13'd1;

    typedef enum logic [2:0] {
        REG_ORIGIN_X       = 3'd0,
        REG_ORIGIN_Y       = 3'd1,
        REG_TEXTURE_WIDTH  = 3'd2,
        REG_TEXTURE_HEIGHT = 3'd3,
        REG_SCREEN_WIDTH   = 3'd4,
        REG_SCREEN_HEIGHT  = 3'd5,
        REG_HAS_ALPHA      = 3'd6
    } reg_index_t;

    function automatic logic [CHAN_BITS-1:0] mix_channel(
        input logic [CHAN_BITS:0]   weight,
        input logic [CHAN_BITS-1:0] tex,
        input logic [CHAN_BITS-1:0] bg
    );
        logic [2*CHAN_BITS:0] sum;
        begin
            sum = (2*CHAN_BITS+1)'(weight) * (2*CHAN_BITS+1)'(tex)
                + (2*CHAN_BITS+1)'(BLEND_ONE - weight) * (2*CHAN_BITS+1)'(bg);
            mix_channel = sum[2*CHAN_BITS-1:CHAN_BITS];
        end
    endfunction

endpackage

@@ rtl/clipped_alpha_texture_blit_core.sv @@
// Each accepted item passes the input register, then the output register.
// Throughput: one texel per cycle back to back; while a result waits, the
// input register takes one more item, then in_ready drops until it drains.
// Reset (rst_n low, asynchronous): pipeline empty, position counters zero,
// registers at origin 0,0, texture 1 x 1, screen 640 x 480, has_alpha 1.
module clipped_alpha_texture_blit_core #(
    parameter int COORD_BITS = catb_pkg::COORD_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [catb_pkg::PADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  texel_red,
    input  logic [7:0]  texel_green,
    input  logic [7:0]  texel_blue,
    input  logic [7:0]  texel_alpha,
    input  logic [31:0] background,

    output logic        out_valid,
    input  logic        out_ready,
    output logic        write_enable,
    output logic [23:0] pixel_address,
    output logic [31:0] pixel_color,
    output logic        end_of_texture
);

    localparam int DIM_W = catb_pkg::DIM_BITS;
    localparam int CMP_W = (COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W;
    localparam int POS_W = ((catb_pkg::ORIGIN_BITS > COORD_BITS)
                            ? catb_pkg::ORIGIN_BITS : COORD_BITS) + 1;
    localparam int PROD_W = POS_W + DIM_W + 1;
    localparam logic [CMP_W-1:0] MAX_DIM = CMP_W'(1) << COORD_BITS;

    logic [catb_pkg::ORIGIN_BITS-1:0] origin_x_reg;
    logic [catb_pkg::ORIGIN_BITS-1:0] origin_y_reg;
    logic [DIM_W-1:0] texture_width_reg;
    logic [DIM_W-1:0] texture_height_reg;
    logic [DIM_W-1:0] screen_width_reg;
    logic [DIM_W-1:0] screen_height_reg;
    logic             has_alpha_reg;

    logic [COORD_BITS-1:0] column_offset_reg;
    logic [COORD_BITS-1:0] row_offset_reg;
    logic [COORD_BITS-1:0] column_offset_next;
    logic [COORD_BITS-1:0] row_offset_next;

    logic        stage_valid_reg;
    logic [7:0]  red_reg;
    logic [7:0]  green_reg;
    logic [7:0]  blue_reg;
    logic [7:0]  alpha_reg;
    logic [31:0] bg_reg;
    logic [POS_W-1:0] x_reg;
    logic [POS_W-1:0] y_reg;
    logic        last_reg;

    logic        out_valid_reg;
    logic        write_enable_reg;
    logic [23:0] pixel_address_reg;
    logic [31:0] pixel_color_reg;
    logic        end_of_texture_reg;

    logic        write_enable_next;
    logic [23:0] pixel_address_next;
    logic [31:0] pixel_color_next;
    logic        last_next;

    logic             cfg_write;
    catb_pkg::reg_index_t cfg_index;
    logic             in_accept;
    logic             stage_ready;
    logic             out_load;
    logic [CMP_W-1:0] tw_clamped;
    logic [CMP_W-1:0] th_clamped;
    logic [CMP_W-1:0] column_plus;
    logic [CMP_W-1:0] row_plus;
    logic [PROD_W-1:0] address_full;
    logic [8:0]       weight;
    logic [7:0]       mix_red;
    logic [7:0]       mix_green;
    logic [7:0]       mix_blue;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = catb_pkg::reg_index_t'(paddr[catb_pkg::PADDR_BITS-1:2]);

    always_comb
    begin
        case (cfg_index)
            catb_pkg::REG_ORIGIN_X:       prdata = 32'(origin_x_reg);
            catb_pkg::REG_ORIGIN_Y:       prdata = 32'(origin_y_reg);
            catb_pkg::REG_TEXTURE_WIDTH:  prdata = 32'(texture_width_reg);
            catb_pkg::REG_TEXTURE_HEIGHT: prdata = 32'(texture_height_reg);
            catb_pkg::REG_SCREEN_WIDTH:   prdata = 32'(screen_width_reg);
            catb_pkg::REG_SCREEN_HEIGHT:  prdata = 32'(screen_height_reg);
            catb_pkg::REG_HAS_ALPHA:      prdata = 32'(has_alpha_reg);
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg       <= '0;
            origin_y_reg       <= '0;
            texture_width_reg  <= catb_pkg::TEXTURE_DIM_RESET;
            texture_height_reg <= catb_pkg::TEXTURE_DIM_RESET;
            screen_width_reg   <= catb_pkg::SCREEN_WIDTH_RESET;
            screen_height_reg  <= catb_pkg::SCREEN_HEIGHT_RESET;
            has_alpha_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                catb_pkg::REG_ORIGIN_X:       origin_x_reg <= pwdata[11:0];
                catb_pkg::REG_ORIGIN_Y:       origin_y_reg <= pwdata[11:0];
                catb_pkg::REG_TEXTURE_WIDTH:  texture_width_reg <= pwdata[12:0];
                catb_pkg::REG_TEXTURE_HEIGHT: texture_height_reg <= pwdata[12:0];
                catb_pkg::REG_SCREEN_WIDTH:   screen_width_reg <= pwdata[12:0];
                catb_pkg::REG_SCREEN_HEIGHT:  screen_height_reg <= pwdata[12:0];
                catb_pkg::REG_HAS_ALPHA:      has_alpha_reg <= pwdata[0];
                default:                      ;
            endcase
        end
    end

    // handshake: each stage takes a new item when empty or when it drains
    assign out_load    = !out_valid_reg || out_ready;
    assign stage_ready = !stage_valid_reg || out_load;
    assign in_ready    = stage_ready;
    assign in_accept   = in_valid && in_ready;

    always_comb
    begin
        if (texture_width_reg == '0)
            tw_clamped = CMP_W'(1);
        else if (CMP_W'(texture_width_reg) > MAX_DIM)
            tw_clamped = MAX_DIM;
        else
            tw_clamped = CMP_W'(texture_width_reg);

        if (texture_height_reg == '0)
            th_clamped = CMP_W'(1);
        else if (CMP_W'(texture_height_reg) > MAX_DIM)
            th_clamped = MAX_DIM;
        else
            th_clamped = CMP_W'(texture_height_reg);

        column_plus = CMP_W'(column_offset_reg) + CMP_W'(1);
        row_plus    = CMP_W'(row_offset_reg) + CMP_W'(1);

        column_offset_next = column_offset_reg;
        row_offset_next    = row_offset_reg;
        last_next          = 1'b0;
        if (column_plus >= tw_clamped)
        begin
            column_offset_next = '0;
            if (row_plus >= th_clamped)
            begin
                row_offset_next = '0;
                last_next       = 1'b1;
            end
            else
            begin
                row_offset_next = row_plus[COORD_BITS-1:0];
            end
        end
        else
        begin
            column_offset_next = column_plus[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_offset_reg <= '0;
            row_offset_reg    <= '0;
            stage_valid_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                column_offset_reg <= column_offset_next;
                row_offset_reg    <= row_offset_next;
            end
            if (stage_ready)
                stage_valid_reg <= in_valid;
            if (out_load)
                out_valid_reg <= stage_valid_reg;
        end
    end

    // input register: hold texel, background, placement and end flag
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            red_reg   <= texel_red;
            green_reg <= texel_green;
            blue_reg  <= texel_blue;
            alpha_reg <= has_alpha_reg ? texel_alpha : catb_pkg::ALPHA_OPAQUE;
            bg_reg    <= background;
            x_reg     <= POS_W'(origin_x_reg) + POS_W'(column_offset_reg);
            y_reg     <= POS_W'(origin_y_reg) + POS_W'(row_offset_reg);
            last_reg  <= last_next;
        end
    end

    assign weight    = 9'(alpha_reg) + 9'd1;
    assign mix_red   = catb_pkg::mix_channel(weight, red_reg, bg_reg[23:16]);
    assign mix_green = catb_pkg::mix_channel(weight, green_reg, bg_reg[15:8]);
    assign mix_blue  = catb_pkg::mix_channel(weight, blue_reg, bg_reg[7:0]);
    assign address_full = PROD_W'(y_reg) * PROD_W'(screen_width_reg) + PROD_W'(x_reg);

    always_comb
    begin
        write_enable_next  = 1'b0;
        pixel_address_next = '0;
        pixel_color_next   = '0;
        if (x_reg < POS_W'(screen_width_reg) && y_reg < POS_W'(screen_height_reg)
            && alpha_reg != catb_pkg::ALPHA_CLEAR)
        begin
            write_enable_next  = 1'b1;
            pixel_address_next = address_full[23:0];
            if (alpha_reg == catb_pkg::ALPHA_OPAQUE)
                pixel_color_next = {catb_pkg::ALPHA_OPAQUE, red_reg, green_reg, blue_reg};
            else
                pixel_color_next = {catb_pkg::ALPHA_OPAQUE, mix_red, mix_green, mix_blue};
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && stage_valid_reg)
        begin
            write_enable_reg   <= write_enable_next;
            pixel_address_reg  <= pixel_address_next;
            pixel_color_reg    <= pixel_color_next;
            end_of_texture_reg <= last_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign write_enable   = write_enable_reg;
    assign pixel_address  = pixel_address_reg;
    assign pixel_color    = pixel_color_reg;
    assign end_of_texture = end_of_texture_reg;

endmodule

@@ rtl/catb_checker.sv @@
module catb_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        write_enable,
    input logic [23:0] pixel_address,
    input logic [31:0] pixel_color,
    input logic        end_of_texture
);

    // stalled result item holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(write_enable)
            && $stable(pixel_address) && $stable(pixel_color)
            && $stable(end_of_texture))
    else $error("stalled result item changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> pixel_address == 24'd0 && pixel_color == 32'd0)
    else $error("dropped item carries nonzero address or color");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_enable |-> pixel_color[31:24] == 8'hFF)
    else $error("written pixel is not opaque in alpha byte");

endmodule

bind clipped_alpha_texture_blit_core catb_checker u_catb_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .write_enable   (write_enable),
    .pixel_address  (pixel_address),
    .pixel_color    (pixel_color),
    .end_of_texture (end_of_texture)
);
